/* hdl/kbgc_pkg.sv */
// shared types and codes for the knob and button gesture classifier
`default_nettype none

package kbgc_pkg;

  // input function codes
  typedef enum logic [1:0] {
    FUNC_ROTATE = 2'd0,
    FUNC_BUTTON = 2'd1,
    FUNC_POLL   = 2'd2,
    FUNC_ENABLE = 2'd3
  } func_t;

  // gesture codes
  typedef enum logic [2:0] {
    GST_NONE    = 3'd0,
    GST_CLICK   = 3'd1,
    GST_DOUBLE  = 3'd2,
    GST_LONG    = 3'd3,
    GST_CONTROL = 3'd4,
    GST_ROTATE  = 3'd5,
    GST_MODE    = 3'd6
  } gesture_t;

  // configuration register indexes
  localparam logic [3:0] REG_CONTROL_MIN   = 4'd0;
  localparam logic [3:0] REG_LONG_MAX      = 4'd1;
  localparam logic [3:0] REG_CLICK_MAX     = 4'd2;
  localparam logic [3:0] REG_DOUBLE_WINDOW = 4'd3;

  // configuration reset values
  localparam logic [15:0] CONTROL_MIN_RST   = 16'd5000;
  localparam logic [15:0] LONG_MAX_RST      = 16'd1500;
  localparam logic [15:0] CLICK_MAX_RST     = 16'd500;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;

  // largest positive 32-bit duration
  localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;

  // direction encodings that act
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  // one result word
  typedef struct packed {
    gesture_t           gesture;
    logic signed [31:0] value;
    logic signed [31:0] hold;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/knob_button_gesture_classifier.sv */
// top level of the knob and button gesture classifier
//
// Input channel (in_valid / in_stall) carries one event word: func selects
// rotate, button edge, poll tick or gesture enable; now_ms is a wrapping
// millisecond time stamp compared modulo 2^TIME_BITS.
// Output channel (out_valid / out_stall) carries one or two result words
// per event, the final one marked by last; every word reports hold_ms.
// An event is registered at acceptance and classified from the input
// register; its results load into a two-entry result buffer once that
// buffer can take them. Events with one result can enter every cycle
// while the output does not stall; after an event with two results the
// next one waits in the input register until the second word is taken,
// as the single output port drains the result buffer one word a cycle.
// A stall on the output holds the current word; once the buffer cannot
// take the registered event, in_stall rises.
// Reset (rst, synchronous) empties both stages, restores the thresholds
// to their defaults and returns the classifier to button up, no click
// waiting, gestures enabled. Configuration writes (cfg_wr) take effect at
// once and are meant for times when no event is in flight.
`default_nettype none

module knob_button_gesture_classifier #(
  parameter int TIME_BITS = 32
) (
  input  wire                clk,
  input  wire                rst,
  // configuration
  input  wire                cfg_wr,
  input  wire  [3:0]         cfg_index,
  input  wire  [15:0]        cfg_data,
  // event channel
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         func,
  input  wire  signed [1:0]  direction,
  input  wire                level,
  input  wire  [31:0]        now_ms,
  // result channel
  output logic               out_valid,
  input  wire                out_stall,
  output logic [2:0]         gesture,
  output logic signed [31:0] value,
  output logic signed [31:0] hold_ms,
  output logic               last
);

  // configuration registers
  logic [15:0] control_min_ms;
  logic [15:0] long_max_ms;
  logic [15:0] click_max_ms;
  logic [15:0] double_window_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_min_ms   <= kbgc_pkg::CONTROL_MIN_RST;
      long_max_ms      <= kbgc_pkg::LONG_MAX_RST;
      click_max_ms     <= kbgc_pkg::CLICK_MAX_RST;
      double_window_ms <= kbgc_pkg::DOUBLE_WINDOW_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        kbgc_pkg::REG_CONTROL_MIN:   control_min_ms   <= cfg_data;
        kbgc_pkg::REG_LONG_MAX:      long_max_ms      <= cfg_data;
        kbgc_pkg::REG_CLICK_MAX:     click_max_ms     <= cfg_data;
        kbgc_pkg::REG_DOUBLE_WINDOW: double_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                 iv;
  kbgc_pkg::func_t      i_func;
  logic [1:0]           i_dir;
  logic                 i_level;
  logic [TIME_BITS-1:0] i_now;

  // result buffer
  kbgc_pkg::res_t r0, r1;
  logic [1:0]     cnt;

  logic out_take, mv;

  assign out_take  = out_valid && !out_stall;
  assign mv        = iv && (cnt == 2'd0 || (cnt == 2'd1 && out_take));
  assign in_stall  = iv && !mv;
  assign out_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv <= 1'b1;
    end else if (mv) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      i_func  <= kbgc_pkg::func_t'(func);
      i_dir   <= direction;
      i_level <= level;
      i_now   <= TIME_BITS'(now_ms);
    end
  end

  // classifier state
  logic                 button_down, button_down_next;
  logic                 turned_while_down, turned_while_down_next;
  logic                 click_waiting, click_waiting_next;
  logic                 gestures_on, gestures_on_next;
  logic [TIME_BITS-1:0] press_stamp, press_stamp_next;
  logic [TIME_BITS-1:0] release_stamp, release_stamp_next;

  // time differences against the stored stamps
  logic [TIME_BITS-1:0] d_press, d_rel;
  logic                 neg_p, neg_r;
  logic [63:0]          dur, since_rel;
  logic [30:0]          dur_sat;

  assign d_press   = i_now - press_stamp;
  assign d_rel     = i_now - release_stamp;
  assign neg_p     = d_press[TIME_BITS-1];
  assign neg_r     = d_rel[TIME_BITS-1];
  assign dur       = neg_p ? 64'd0 : 64'(d_press);
  assign since_rel = neg_r ? 64'd0 : 64'(d_rel);
  assign dur_sat   = (dur > kbgc_pkg::POS_MAX) ? 31'h7FFF_FFFF : dur[30:0];

  // classification
  kbgc_pkg::gesture_t g0, g1;
  logic [31:0]        v0, v1;
  logic [1:0]         n;
  logic               pressed_now;
  logic [31:0]        dir_val;
  logic [31:0]        hold_val;
  kbgc_pkg::res_t     new0, new1;

  assign dir_val = (i_dir == kbgc_pkg::DIR_UP) ? 32'd1 : 32'hFFFF_FFFF;

  always_comb begin
    button_down_next       = button_down;
    turned_while_down_next = turned_while_down;
    click_waiting_next     = click_waiting;
    gestures_on_next       = gestures_on;
    press_stamp_next       = press_stamp;
    release_stamp_next     = release_stamp;
    g0          = kbgc_pkg::GST_NONE;
    g1          = kbgc_pkg::GST_NONE;
    v0          = 32'd0;
    v1          = 32'd0;
    n           = 2'd0;
    pressed_now = 1'b0;
    case (i_func)
      kbgc_pkg::FUNC_ROTATE: begin
        if (i_dir == kbgc_pkg::DIR_UP || i_dir == kbgc_pkg::DIR_DOWN) begin
          if (button_down) begin
            turned_while_down_next = 1'b1;
            g0 = kbgc_pkg::GST_MODE;
            v0 = dir_val;
            n  = 2'd1;
          end else if (click_waiting) begin
            // flush pending click ahead of the rotation
            click_waiting_next = 1'b0;
            g0 = kbgc_pkg::GST_CLICK;
            g1 = kbgc_pkg::GST_ROTATE;
            v1 = dir_val;
            n  = 2'd2;
          end else begin
            g0 = kbgc_pkg::GST_ROTATE;
            v0 = dir_val;
            n  = 2'd1;
          end
        end
      end
      kbgc_pkg::FUNC_BUTTON: begin
        if (i_level) begin
          if (!button_down) begin
            button_down_next       = 1'b1;
            press_stamp_next       = i_now;
            turned_while_down_next = 1'b0;
            pressed_now            = 1'b1;
          end
        end else if (button_down) begin
          button_down_next = 1'b0;
          if (turned_while_down) begin
            turned_while_down_next = 1'b0;
          end else if (dur >= 64'(control_min_ms)) begin
            g0 = kbgc_pkg::GST_CONTROL;
            v0 = {1'b0, dur_sat};
            n  = 2'd1;
          end else if (dur >= 64'(long_max_ms)) begin
            // dead band gives no gesture
          end else if (!gestures_on) begin
            g0 = kbgc_pkg::GST_CLICK;
            n  = 2'd1;
          end else if (dur >= 64'(click_max_ms)) begin
            g0 = kbgc_pkg::GST_LONG;
            n  = 2'd1;
          end else if (click_waiting
                       && (neg_r || since_rel < 64'(double_window_ms))) begin
            click_waiting_next = 1'b0;
            g0 = kbgc_pkg::GST_DOUBLE;
            n  = 2'd1;
          end else begin
            // older click gives up its partner, new one starts waiting
            if (click_waiting) begin
              g0 = kbgc_pkg::GST_CLICK;
              n  = 2'd1;
            end
            click_waiting_next = 1'b1;
            release_stamp_next = i_now;
          end
        end
      end
      kbgc_pkg::FUNC_POLL: begin
        if (click_waiting && !neg_r && since_rel >= 64'(double_window_ms)) begin
          click_waiting_next = 1'b0;
          g0 = kbgc_pkg::GST_CLICK;
          n  = 2'd1;
        end
      end
      kbgc_pkg::FUNC_ENABLE: begin
        if (gestures_on && !i_level && click_waiting) begin
          click_waiting_next = 1'b0;
          g0 = kbgc_pkg::GST_CLICK;
          n  = 2'd1;
        end
        gestures_on_next = i_level;
      end
      default: ;
    endcase
    if (n == 2'd0) begin
      n = 2'd1;
    end
  end

  // hold time seen after this event
  always_comb begin
    if (!button_down_next || turned_while_down_next) begin
      hold_val = 32'hFFFF_FFFF;
    end else if (pressed_now) begin
      hold_val = 32'd0;
    end else begin
      hold_val = {1'b0, dur_sat};
    end
  end

  always_comb begin
    new0.gesture = g0;
    new0.value   = v0;
    new0.hold    = hold_val;
    new0.last    = (n == 2'd1);
    new1.gesture = g1;
    new1.value   = v1;
    new1.hold    = hold_val;
    new1.last    = 1'b1;
  end

  // state update when the event leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      button_down       <= 1'b0;
      turned_while_down <= 1'b0;
      click_waiting     <= 1'b0;
      gestures_on       <= 1'b1;
      press_stamp       <= '0;
      release_stamp     <= '0;
    end else if (mv) begin
      button_down       <= button_down_next;
      turned_while_down <= turned_while_down_next;
      click_waiting     <= click_waiting_next;
      gestures_on       <= gestures_on_next;
      press_stamp       <= press_stamp_next;
      release_stamp     <= release_stamp_next;
    end
  end

  // result buffer count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (mv) begin
      cnt <= n;
    end else if (out_take) begin
      cnt <= cnt - 2'd1;
    end
  end

  // result buffer words
  always_ff @(posedge clk) begin
    if (mv) begin
      r0 <= new0;
      r1 <= new1;
    end else if (out_take) begin
      r0 <= r1;
    end
  end

  assign gesture = r0.gesture;
  assign value   = r0.value;
  assign hold_ms = r0.hold;
  assign last    = r0.last;

endmodule

`default_nettype wire

/* hdl/kbgc_checker.sv */
// port-level checks for the knob and button gesture classifier
`default_nettype none

module kbgc_checker (
  input wire               clk,
  input wire               rst,
  input wire               out_valid,
  input wire               out_stall,
  input wire [2:0]         gesture,
  input wire signed [31:0] value,
  input wire signed [31:0] hold_ms,
  input wire               last
);

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word visible right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gesture) && $stable(value)
      && $stable(hold_ms) && $stable(last))
    else $error("stalled result word changed");

  // the first of two words always carries a gesture
  a_first_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> gesture != kbgc_pkg::GST_NONE
      && gesture <= kbgc_pkg::GST_MODE)
    else $error("leading word without a gesture");

  // rotation words carry a unit step
  a_rotate_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && (gesture == kbgc_pkg::GST_ROTATE || gesture == kbgc_pkg::GST_MODE)
      |-> value == 32'sd1 || value == -32'sd1)
    else $error("rotation word without unit direction");

  // hold time is never below the not-held mark
  a_hold_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hold_ms >= -32'sd1)
    else $error("hold time out of range");

endmodule

bind knob_button_gesture_classifier kbgc_checker u_kbgc_checker (.*);

`default_nettype wire
